// ----- hdl/pcxrle_pkg.sv -----
// pcxrle_pkg: shared types and constants for the pcx run-length scanline decoder
// used by the front, queue, back and top-level modules; no dependencies
package pcxrle_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 6;
  localparam int unsigned RegW   = 15;
  localparam int unsigned LineW  = 16;
  localparam int unsigned IdxW   = 2;

  localparam logic [ByteW-1:0] RunMark = 8'hC0;
  localparam logic [ByteW-1:0] RunMask = 8'h3F;

  localparam logic [IdxW-1:0] RegLineBytes = 2'd0;
  localparam logic [IdxW-1:0] RegLineCount = 2'd1;

  localparam logic [RegW-1:0] LineBytesRst = 15'd320;
  localparam logic [RegW-1:0] LineCountRst = 15'd200;

  // one expansion command handed from front to back
  typedef struct packed {
    logic [ByteW-1:0]  pixel;
    logic [CountW-1:0] count;
    logic              line_end;
    logic              image_end;
  } cmd_t;

endpackage

// ----- hdl/pcxrle_front.sv -----
// pcxrle_front: accepts code bytes, decodes run codes, keeps line and image counters
// and issues expansion commands; depends on pcxrle_pkg
module pcxrle_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pcxrle_pkg::IdxW-1:0]    cfg_idx_i,
  input  logic [pcxrle_pkg::RegW-1:0]    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [pcxrle_pkg::ByteW-1:0]   code_byte_i,
  input  logic                           start_image_i,
  input  logic                           q_full_i,
  output logic                           push_o,
  output pcxrle_pkg::cmd_t               cmd_o
);
  import pcxrle_pkg::*;

  logic [RegW-1:0]   line_bytes_q, line_count_q;
  logic              await_q, await_d;
  logic [CountW-1:0] pending_q, pending_d;
  logic [LineW-1:0]  bytes_q, bytes_d;
  logic [RegW-1:0]   lines_q, lines_d;
  logic              done_q, done_d;

  logic              accept, is_run, emit, line_hit, img_hit;
  logic [CountW-1:0] cnt;
  logic [LineW-1:0]  bytes_sum;
  logic [RegW-1:0]   lines_inc;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_run     = (code_byte_i & RunMark) == RunMark;
  assign cnt        = await_q ? pending_q : CountW'(1);
  assign bytes_sum  = bytes_q + LineW'(cnt);
  assign line_hit   = bytes_sum >= {1'b0, line_bytes_q};
  assign lines_inc  = lines_q + RegW'(1);
  assign img_hit    = line_hit && (lines_inc >= line_count_q);
  assign emit       = accept && !start_image_i && !done_q &&
                      (await_q ? (pending_q != '0) : !is_run);

  always_comb begin
    await_d   = await_q;
    pending_d = pending_q;
    bytes_d   = bytes_q;
    lines_d   = lines_q;
    done_d    = done_q;
    if (accept) begin
      if (start_image_i) begin
        await_d   = 1'b0;
        pending_d = '0;
        bytes_d   = '0;
        lines_d   = '0;
        done_d    = 1'b0;
      end else if (!done_q) begin
        if (await_q) begin
          await_d   = 1'b0;
          pending_d = '0;
        end else if (is_run) begin
          await_d   = 1'b1;
          pending_d = CountW'(code_byte_i & RunMask);
        end
        if (emit) begin
          if (line_hit) begin
            bytes_d = '0;
            if (img_hit) begin
              lines_d = '0;
              done_d  = 1'b1;
            end else begin
              lines_d = lines_inc;
            end
          end else begin
            bytes_d = bytes_sum;
          end
        end
      end
    end
  end

  assign push_o          = emit;
  assign cmd_o.pixel     = code_byte_i;
  assign cmd_o.count     = cnt;
  assign cmd_o.line_end  = line_hit;
  assign cmd_o.image_end = img_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_bytes_q <= LineBytesRst;
      line_count_q <= LineCountRst;
      await_q      <= 1'b0;
      pending_q    <= '0;
      bytes_q      <= '0;
      lines_q      <= '0;
      done_q       <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == RegLineBytes) begin
        line_bytes_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == RegLineCount) begin
        line_count_q <= cfg_data_i;
      end
      await_q   <= await_d;
      pending_q <= pending_d;
      bytes_q   <= bytes_d;
      lines_q   <= lines_d;
      done_q    <= done_d;
    end
  end

endmodule

// ----- hdl/pcxrle_queue.sv -----
// pcxrle_queue: short register queue of expansion commands between front and back
// depends on pcxrle_pkg
module pcxrle_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  pcxrle_pkg::cmd_t cmd_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output pcxrle_pkg::cmd_t cmd_o
);
  import pcxrle_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign valid_o = cnt_q != '0;
  assign cmd_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- hdl/pcxrle_back.sv -----
// pcxrle_back: expands queued commands into pixel items through an output register
// depends on pcxrle_pkg
module pcxrle_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  pcxrle_pkg::cmd_t              cmd_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pcxrle_pkg::ByteW-1:0]  pixel_o,
  output logic                          line_end_o,
  output logic                          image_end_o,
  output logic                          last_of_input_o
);
  import pcxrle_pkg::*;

  logic              valid_q, valid_d;
  logic [ByteW-1:0]  pixel_q, pixel_d;
  logic [CountW-1:0] left_q, left_d;
  logic              lend_q, lend_d, iend_q, iend_d;
  logic              last, take;

  assign last  = left_q == CountW'(1);
  assign take  = valid_q && out_ready_i;
  assign pop_o = q_valid_i && (!valid_q || (take && last));

  always_comb begin
    valid_d = valid_q;
    pixel_d = pixel_q;
    left_d  = left_q;
    lend_d  = lend_q;
    iend_d  = iend_q;
    if (pop_o) begin
      valid_d = 1'b1;
      pixel_d = cmd_i.pixel;
      left_d  = cmd_i.count;
      lend_d  = cmd_i.line_end;
      iend_d  = cmd_i.image_end;
    end else if (take) begin
      if (last) begin
        valid_d = 1'b0;
      end else begin
        left_d = left_q - CountW'(1);
      end
    end
  end

  assign out_valid_o     = valid_q;
  assign pixel_o         = pixel_q;
  assign last_of_input_o = last;
  assign line_end_o      = last && lend_q;
  assign image_end_o     = last && iend_q;

  always_ff @(posedge clk_i) begin
    pixel_q <= pixel_d;
    left_q  <= left_d;
    lend_q  <= lend_d;
    iend_q  <= iend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

endmodule

// ----- hdl/pcx_rle_scanline_decoder.sv -----
// pcx_rle_scanline_decoder: top level of the pcx run-length scanline decoder
// depends on pcxrle_pkg, pcxrle_front, pcxrle_queue and pcxrle_back
//
// The decoder takes one compressed byte per item and returns decoded pixel items.
// A literal byte is written into the command queue, and its pixel is then presented
// by the single output register of the expansion stage; a run code byte yields
// nothing, and its value byte yields count pixels back to back as the output
// accepts them, so a run of n takes two input items and n output items.
// Input bytes keep flowing into a queue of QueueDepth commands while a run expands;
// input stalls only when it is full.
// line_end and image_end mark the last pixel of the code that completes a line or
// the image; after the image ends, bytes are dropped until a start item arrives.
module pcx_rle_scanline_decoder #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pcxrle_pkg::IdxW-1:0]   cfg_idx_i,
  input  logic [pcxrle_pkg::RegW-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [pcxrle_pkg::ByteW-1:0]  code_byte_i,
  input  logic                          start_image_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pcxrle_pkg::ByteW-1:0]  pixel_o,
  output logic                          line_end_o,
  output logic                          image_end_o,
  output logic                          last_of_input_o
);
  import pcxrle_pkg::*;

  logic q_full, push, pop, q_valid;
  cmd_t push_cmd, pop_cmd;

  pcxrle_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .code_byte_i   (code_byte_i),
    .start_image_i (start_image_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  pcxrle_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (pop_cmd)
  );

  pcxrle_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .cmd_i           (pop_cmd),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pixel_o         (pixel_o),
    .line_end_o      (line_end_o),
    .image_end_o     (image_end_o),
    .last_of_input_o (last_of_input_o)
  );

endmodule

// ----- sim/pcx_rle_scanline_decoder_test.sv -----
// pcx_rle_scanline_decoder_test: self-checking bench for the pcx run-length scanline decoder
// drives literal, run and start items with random gaps and back-pressure, predicts pixels
// in a small scoreboard class; depends on pcxrle_pkg and pcx_rle_scanline_decoder
module pcx_rle_scanline_decoder_test;
  import pcxrle_pkg::*;

  localparam logic [IdxW-1:0] RegSpare2 = 2'd2;
  localparam logic [IdxW-1:0] RegSpare3 = 2'd3;

  typedef struct packed {
    logic [ByteW-1:0] pixel;
    logic             line_end;
    logic             image_end;
    logic             last;
  } pixel_t;

  class pixel_scoreboard;
    logic [RegW-1:0]   line_bytes_q;
    logic [RegW-1:0]   line_count_q;
    bit                await_run;
    logic [CountW-1:0] run_len;
    logic [LineW-1:0]  line_pos;
    logic [RegW-1:0]   lines;
    bit                img_done;
    pixel_t            due[$];
    int                used;
    int                errors;
    int                shown;

    function new();
      line_bytes_q = LineBytesRst;
      line_count_q = LineCountRst;
      await_run    = 1'b0;
      run_len      = '0;
      line_pos     = '0;
      lines        = '0;
      img_done     = 1'b0;
      used         = 0;
      errors       = 0;
      shown        = 0;
    endfunction

    function void set_reg(logic [IdxW-1:0] idx, logic [RegW-1:0] val);
      case (idx)
        RegLineBytes: line_bytes_q = val;
        RegLineCount: line_count_q = val;
        default: ;
      endcase
    endfunction

    function void note_item(logic [ByteW-1:0] b, logic st);
      int     cnt;
      bit     lend;
      bit     iend;
      pixel_t e;
      if (st) begin
        await_run = 1'b0;
        run_len   = '0;
        line_pos  = '0;
        lines     = '0;
        img_done  = 1'b0;
        used++;
        return;
      end
      if (img_done) return;
      used++;
      if (await_run) begin
        await_run = 1'b0;
        cnt       = run_len;
        run_len   = '0;
      end else if ((b & RunMark) == RunMark) begin
        await_run = 1'b1;
        run_len   = CountW'(b & RunMask);
        return;
      end else begin
        cnt = 1;
      end
      if (cnt == 0) return;
      lend     = 1'b0;
      iend     = 1'b0;
      line_pos = line_pos + LineW'(cnt);
      if (line_pos >= {1'b0, line_bytes_q}) begin
        lend     = 1'b1;
        line_pos = '0;
        lines    = lines + RegW'(1);
        if (lines >= line_count_q) begin
          iend     = 1'b1;
          img_done = 1'b1;
          lines    = '0;
        end
      end
      for (int k = 0; k < cnt; k++) begin
        e.pixel     = b;
        e.last      = (k == cnt - 1);
        e.line_end  = e.last && lend;
        e.image_end = e.last && iend;
        due.push_back(e);
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t e;
      if (due.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected pixel %h line_end %b image_end %b last %b",
                   got.pixel, got.line_end, got.image_end, got.last);
        end
        return;
      end
      e = due.pop_front();
      if (got !== e) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("mismatch: expected pixel %h le %b ie %b last %b, got %h le %b ie %b last %b",
                   e.pixel, e.line_end, e.image_end, e.last,
                   got.pixel, got.line_end, got.image_end, got.last);
        end
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic             clk_i           = 1'b0;
  logic             rst_ni          = 1'b0;
  logic             cfg_we_i        = 1'b0;
  logic [IdxW-1:0]  cfg_idx_i       = '0;
  logic [RegW-1:0]  cfg_data_i      = '0;
  logic             in_valid_i      = 1'b0;
  logic             in_ready_o;
  logic [ByteW-1:0] code_byte_i     = '0;
  logic             start_image_i   = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i     = 1'b0;
  logic [ByteW-1:0] pixel_o;
  logic             line_end_o;
  logic             image_end_o;
  logic             last_of_input_o;

  pixel_scoreboard sb = new();
  int send_quiet = 0;
  int recv_quiet = 0;
  bit held       = 1'b0;

  pcx_rle_scanline_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .code_byte_i     (code_byte_i),
    .start_image_i   (start_image_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pixel_o         (pixel_o),
    .line_end_o      (line_end_o),
    .image_end_o     (image_end_o),
    .last_of_input_o (last_of_input_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic int pick_gap(inout int quiet);
    int r;
    r = $urandom_range(99);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if (r < 4) begin
      quiet = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  task automatic send_item(input logic [ByteW-1:0] b, input logic st);
    int gap;
    code_byte_i   <= b;
    start_image_i <= st;
    in_valid_i    <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_item(b, st);
    gap = pick_gap(send_quiet);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic random_item();
    int                r;
    logic [CountW-1:0] n;
    r = $urandom_range(99);
    if (sb.img_done) begin
      send_item(ByteW'($urandom), r < 85);
    end else if (r < 3) begin
      send_item(ByteW'($urandom), 1'b1);
    end else if (r < 45) begin
      send_item(ByteW'($urandom_range(0, 191)), 1'b0);
    end else if (r < 90) begin
      n = ($urandom_range(9) == 0) ? CountW'($urandom_range(9, 63))
                                   : CountW'($urandom_range(0, 8));
      send_item(RunMark | ByteW'(n), 1'b0);
      send_item(ByteW'($urandom), 1'b0);
    end else begin
      send_item(ByteW'($urandom), 1'($urandom));
    end
  endtask

  task automatic set_config(input logic [RegW-1:0] lb, input logic [RegW-1:0] lc);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= RegLineBytes;
    cfg_data_i <= lb;
    @(posedge clk_i);
    cfg_idx_i  <= RegLineCount;
    cfg_data_i <= lc;
    @(posedge clk_i);
    cfg_idx_i  <= $urandom_range(1) ? RegSpare2 : RegSpare3;
    cfg_data_i <= RegW'($urandom);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_reg(RegLineBytes, lb);
    sb.set_reg(RegLineCount, lc);
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  // result side: random stalls, one long hold-off once traffic is flowing
  initial begin
    int hold;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      if (!held && sb.used >= 150) begin
        held = 1'b1;
        hold = 400;
      end else begin
        hold = pick_gap(recv_quiet);
      end
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_pixel('{pixel_o, line_end_o, image_end_o, last_of_input_o});
    end
  end

  initial begin
    // bit 8 is start_image
    logic [8:0] warmup [18] = '{
      9'h1A5, 9'h000, 9'h0BF, 9'h040, 9'h0C0, 9'h012, 9'h080, 9'h0C2, 9'h0FF,
      9'h0FF, 9'h0C3, 9'h055, 9'h0C7, 9'h0FF, 9'h100, 9'h0C1, 9'h000, 9'h07F
    };
    int              target;
    logic [RegW-1:0] lb;
    logic [RegW-1:0] lc;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_config(15'd4, 15'd2);
    foreach (warmup[i]) send_item(warmup[i][7:0], warmup[i][8]);
    in_valid_i <= 1'b0;
    drain();
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin
          lb = 15'd1;
          lc = 15'd1;
        end
        1: begin
          lb = 15'd32767;
          lc = 15'd32767;
        end
        // zero registers act like one, and lowering mid-image ends it at once
        2: begin
          lb = 15'd0;
          lc = 15'd0;
        end
        3: begin
          lb = 15'd3;
          lc = 15'd32767;
        end
        default: begin
          lb = RegW'($urandom_range(1, 48));
          lc = RegW'($urandom_range(1, 6));
        end
      endcase
      set_config(lb, lc);
      target = sb.used + 55;
      while (sb.used < target) random_item();
      in_valid_i <= 1'b0;
      drain();
    end
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS pcx_rle_scanline_decoder");
    end else begin
      $display("FAIL pcx_rle_scanline_decoder");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("FAIL pcx_rle_scanline_decoder");
    $finish;
  end

endmodule
